// ===== rtl/dcalc_pkg.sv =====
`default_nettype none

package dcalc_pkg;

  localparam int DIGIT_COUNT_DEF = 6;
  localparam int DIGIT_W         = 4;

  // field widths on the ports
  localparam int CMD_W       = 3;
  localparam int POS_W       = 3;
  localparam int VAL_W       = 4;
  localparam int BCD_W       = 24;
  localparam int VALUE_W     = 20;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 3;

  localparam logic [VAL_W-1:0] DIGIT_MAX = 4'd9;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR_X = 3'd0,
    CMD_CLEAR_Y = 3'd1,
    CMD_SET_X   = 3'd2,
    CMD_SET_Y   = 3'd3,
    CMD_ADD     = 3'd4,
    CMD_SUB     = 3'd5,
    CMD_MUL     = 3'd6,
    CMD_DIV     = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NEGATIVE = 2'd2,
    ST_DIVZERO  = 2'd3
  } status_t;

  // 10 to the n, evaluated at elaboration
  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dcalc_bin2bcd.sv =====
`default_nettype none

module dcalc_bin2bcd #(
  parameter int NUM_W       = 20,
  parameter int DIGIT_COUNT = dcalc_pkg::DIGIT_COUNT_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    start,
  input  wire logic [NUM_W-1:0]                        value,
  output logic                                         done,
  output logic [DIGIT_COUNT*dcalc_pkg::DIGIT_W-1:0]    bcd
);

  localparam int DW    = dcalc_pkg::DIGIT_W;
  localparam int BW    = DIGIT_COUNT * DW;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh_r, sh_nxt;
  logic [BW-1:0]    bcd_r, bcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BW-1:0]    adj;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd_r[i*DW +: DW] >= DW'(5)) begin
        adj[i*DW +: DW] = bcd_r[i*DW +: DW] + DW'(3);
      end else begin
        adj[i*DW +: DW] = bcd_r[i*DW +: DW];
      end
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = value;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[BW-2:0], sh_r[NUM_W-1]};
      sh_nxt  = {sh_r[NUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

`default_nettype wire

// ===== rtl/decimal_calculator_core.sv =====
// from input transfer to out_tvalid: clears and error exits pass S_EXEC and S_DONE, digit sets
// add a horner pass over the digits, add and subtract a bcd split, multiply and divide a bit-serial
// loop over NUM_W = bits of 10^DIGIT_COUNT, then a bcd split; an overflowing multiply stops early
// one item at a time: in_tready rises with out_tvalid, so a new item starts once a result is loaded,
// later if the previous result still waits; one shared add/subtract unit and a bit-serial bcd split
// synchronous active-low reset zeroes both operands and empties the output register
`default_nettype none

module decimal_calculator_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // command[2:0], digit_position[5:3], digit_value[9:6], zero pad
  input  wire logic [dcalc_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // x_bcd[23:0], x_value[43:24], remainder[63:44]
  output logic [dcalc_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // remainder_valid[0], status[2:1]
  output logic [dcalc_pkg::OUT_TUSER_W-1:0]        out_tuser
);

  localparam int DIGIT_COUNT = dcalc_pkg::DIGIT_COUNT_DEF;
  localparam int DW    = dcalc_pkg::DIGIT_W;
  localparam int BW    = DIGIT_COUNT * DW;
  localparam longint unsigned LIMIT = dcalc_pkg::pow10(DIGIT_COUNT);
  localparam int NUM_W = $clog2(LIMIT);
  localparam int UW    = NUM_W + 2;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int IDX_W = $clog2(NUM_W);
  localparam logic [UW-1:0] LIMIT_V = UW'(LIMIT);

  localparam int POS_LO = dcalc_pkg::CMD_W;
  localparam int VAL_LO = POS_LO + dcalc_pkg::POS_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_HORNER = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_CONV   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                            state_r, state_nxt;
  dcalc_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [dcalc_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [dcalc_pkg::VAL_W-1:0]       val_r, val_nxt;
  logic [dcalc_pkg::VAL_W-1:0]       in_val;

  logic [NUM_W-1:0]                  x_num_r, x_num_nxt;
  logic [NUM_W-1:0]                  y_num_r, y_num_nxt;
  logic [BW-1:0]                     x_dig_r, x_dig_nxt;
  logic [BW-1:0]                     y_dig_r, y_dig_nxt;

  logic [UW-1:0]                     acc_r, acc_nxt;
  logic [NUM_W-1:0]                  quo_r, quo_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]                  cnt_m1;

  dcalc_pkg::status_t                status_r, status_nxt;
  logic [NUM_W-1:0]                  rem_r, rem_nxt;
  logic                              rvalid_r, rvalid_nxt;
  logic                              conv_start_r, conv_start_nxt;

  logic                              out_tvalid_r, out_tvalid_nxt;
  logic [dcalc_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [dcalc_pkg::OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  // shared add/subtract unit
  logic [UW-1:0]                     unit_a, unit_b, unit_res;
  logic                              unit_sub;

  logic [BW-1:0]                     horner_src;
  logic [DW-1:0]                     horner_digit;
  logic                              conv_done;
  logic [BW-1:0]                     conv_bcd;
  logic                              qbit;

  assign in_val = in_tdata[VAL_LO +: dcalc_pkg::VAL_W];
  assign cnt_m1 = cnt_r - CNT_W'(1);

  dcalc_bin2bcd #(
    .NUM_W       (NUM_W),
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_bin2bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start_r),
    .value (x_num_r),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // digit for the current horner step, most significant first
  always_comb begin
    horner_src   = (cmd_r == dcalc_pkg::CMD_SET_Y) ? y_dig_r : x_dig_r;
    horner_digit = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (cnt_r == CNT_W'(i + 1)) begin
        horner_digit = horner_src[i*DW +: DW];
      end
    end
  end

  always_comb begin
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    unique case (state_r)
      S_EXEC: begin
        unit_a   = UW'(x_num_r);
        unit_b   = UW'(y_num_r);
        unit_sub = (cmd_r == dcalc_pkg::CMD_SUB);
      end
      S_HORNER: begin
        // acc * 10 + digit
        unit_a = UW'({acc_r, 3'b000});
        unit_b = UW'({acc_r, 1'b0}) + UW'(horner_digit);
      end
      S_MUL: begin
        unit_a = UW'({acc_r, 1'b0});
        unit_b = y_num_r[cnt_m1[IDX_W-1:0]] ? UW'(x_num_r) : '0;
      end
      S_DIV: begin
        unit_a   = UW'({acc_r[NUM_W-1:0], quo_r[NUM_W-1]});
        unit_b   = UW'(y_num_r);
        unit_sub = 1'b1;
      end
      default: begin
        unit_a = '0;
      end
    endcase
  end

  assign unit_res = unit_sub ? (unit_a - unit_b) : (unit_a + unit_b);
  // operands stay below 2^(NUM_W+1), so the top bit is the borrow
  assign qbit = !unit_res[UW-1];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    x_num_nxt      = x_num_r;
    y_num_nxt      = y_num_r;
    x_dig_nxt      = x_dig_r;
    y_dig_nxt      = y_dig_r;
    acc_nxt        = acc_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    rem_nxt        = rem_r;
    rvalid_nxt     = rvalid_r;
    conv_start_nxt = 1'b0;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = dcalc_pkg::cmd_t'(in_tdata[dcalc_pkg::CMD_W-1:0]);
          pos_nxt   = in_tdata[POS_LO +: dcalc_pkg::POS_W];
          val_nxt   = (in_val > dcalc_pkg::DIGIT_MAX) ? dcalc_pkg::DIGIT_MAX : in_val;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = dcalc_pkg::ST_OK;
        rem_nxt    = '0;
        rvalid_nxt = 1'b0;
        unique case (cmd_r) inside
          dcalc_pkg::CMD_CLEAR_X: begin
            x_num_nxt = '0;
            x_dig_nxt = '0;
            state_nxt = S_DONE;
          end
          dcalc_pkg::CMD_CLEAR_Y: begin
            y_num_nxt = '0;
            y_dig_nxt = '0;
            state_nxt = S_DONE;
          end
          dcalc_pkg::CMD_SET_X, dcalc_pkg::CMD_SET_Y: begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
              if ({1'b0, pos_r} == 4'(i)) begin
                if (cmd_r == dcalc_pkg::CMD_SET_X) begin
                  x_dig_nxt[i*DW +: DW] = val_r;
                end else begin
                  y_dig_nxt[i*DW +: DW] = val_r;
                end
              end
            end
            acc_nxt   = '0;
            cnt_nxt   = CNT_W'(DIGIT_COUNT);
            state_nxt = S_HORNER;
          end
          dcalc_pkg::CMD_ADD: begin
            if (unit_res >= LIMIT_V) begin
              status_nxt = dcalc_pkg::ST_OVERFLOW;
              state_nxt  = S_DONE;
            end else begin
              x_num_nxt      = unit_res[NUM_W-1:0];
              conv_start_nxt = 1'b1;
              state_nxt      = S_CONV;
            end
          end
          dcalc_pkg::CMD_SUB: begin
            if (unit_res[UW-1]) begin
              status_nxt = dcalc_pkg::ST_NEGATIVE;
              state_nxt  = S_DONE;
            end else begin
              x_num_nxt      = unit_res[NUM_W-1:0];
              conv_start_nxt = 1'b1;
              state_nxt      = S_CONV;
            end
          end
          dcalc_pkg::CMD_MUL: begin
            acc_nxt   = '0;
            cnt_nxt   = CNT_W'(NUM_W);
            state_nxt = S_MUL;
          end
          dcalc_pkg::CMD_DIV: begin
            if (y_num_r == '0) begin
              status_nxt = dcalc_pkg::ST_DIVZERO;
              state_nxt  = S_DONE;
            end else begin
              acc_nxt   = '0;
              quo_nxt   = x_num_r;
              cnt_nxt   = CNT_W'(NUM_W);
              state_nxt = S_DIV;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_HORNER: begin
        acc_nxt = unit_res;
        cnt_nxt = cnt_m1;
        if (cnt_r == CNT_W'(1)) begin
          if (cmd_r == dcalc_pkg::CMD_SET_X) begin
            x_num_nxt = unit_res[NUM_W-1:0];
          end else begin
            y_num_nxt = unit_res[NUM_W-1:0];
          end
          state_nxt = S_DONE;
        end
      end

      S_MUL: begin
        // partial product only grows, so stop at the first overflow
        if (unit_res >= LIMIT_V) begin
          status_nxt = dcalc_pkg::ST_OVERFLOW;
          state_nxt  = S_DONE;
        end else begin
          acc_nxt = unit_res;
          cnt_nxt = cnt_m1;
          if (cnt_r == CNT_W'(1)) begin
            x_num_nxt      = unit_res[NUM_W-1:0];
            conv_start_nxt = 1'b1;
            state_nxt      = S_CONV;
          end
        end
      end

      S_DIV: begin
        acc_nxt = qbit ? unit_res : unit_a;
        quo_nxt = {quo_r[NUM_W-2:0], qbit};
        cnt_nxt = cnt_m1;
        if (cnt_r == CNT_W'(1)) begin
          x_num_nxt      = quo_nxt;
          rem_nxt        = acc_nxt[NUM_W-1:0];
          rvalid_nxt     = 1'b1;
          conv_start_nxt = 1'b1;
          state_nxt      = S_CONV;
        end
      end

      S_CONV: begin
        if (conv_done) begin
          x_dig_nxt = conv_bcd;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {dcalc_pkg::VALUE_W'(rem_r), dcalc_pkg::VALUE_W'(x_num_r),
                            dcalc_pkg::BCD_W'(x_dig_r)};
          out_tuser_nxt  = {status_r, rvalid_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      x_num_r      <= '0;
      y_num_r      <= '0;
      x_dig_r      <= '0;
      y_dig_r      <= '0;
      cnt_r        <= '0;
      status_r     <= dcalc_pkg::ST_OK;
      rvalid_r     <= 1'b0;
      conv_start_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      x_num_r      <= x_num_nxt;
      y_num_r      <= y_num_nxt;
      x_dig_r      <= x_dig_nxt;
      y_dig_r      <= y_dig_nxt;
      cnt_r        <= cnt_nxt;
      status_r     <= status_nxt;
      rvalid_r     <= rvalid_nxt;
      conv_start_r <= conv_start_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r       <= cmd_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    acc_r       <= acc_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    UW'(x_num_r) < LIMIT_V)
    else $error("x operand out of range");

  a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    UW'(y_num_r) < LIMIT_V)
    else $error("y operand out of range");

  a_rem_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> (status_r == dcalc_pkg::ST_OK))
    else $error("remainder flagged with error status");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in work");

  a_conv_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> (state_r == S_CONV))
    else $error("digit split finished outside conversion");
`endif

endmodule

`default_nettype wire
